// ===== rtl/bayer_dither_gray4_packer_defines.svh =====
// assertion macros shared by the dither packer rtl
// no dependencies; included by modules that carry assertions
`ifndef BAYER_DITHER_GRAY4_PACKER_DEFINES_SVH
`define BAYER_DITHER_GRAY4_PACKER_DEFINES_SVH

// same-cycle implication
`define BDG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bdg_pkg.sv =====
// shared types, constants and the bayer threshold table for the dither packer
// no dependencies
`timescale 1ns / 1ps

package bdg_pkg;

  localparam int unsigned MAX_DIMENSION_DEF = 1024;
  localparam int unsigned CFG_DIM_W = 11;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam logic [CFG_DIM_W-1:0] WIDTH_RESET = 11'd492;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 11'd560;

  localparam int unsigned LUMA_R = 30;
  localparam int unsigned LUMA_G = 59;
  localparam int unsigned LUMA_B = 11;
  localparam int unsigned LUMA_DIV = 100;
  localparam int unsigned BAYER_SCALE = 4;
  // gray >= 4*m  <=>  sum >= 400*m, so no divide is needed
  localparam int unsigned THRESH_SCALE = BAYER_SCALE * LUMA_DIV;
  localparam int unsigned LUMA_SUM_W = 15;

  localparam logic [3:0] IDX_WHITE = 4'h0;
  localparam logic [3:0] IDX_BLACK = 4'hF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_SWAP_RB      = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [8:0] byte_column;
    logic [9:0] row_index;
    logic [2:0] bayer_row;
    logic [2:0] bayer_col;
    logic       last_col;
    logic       last_row;
  } pos_t;

  localparam logic [5:0] BAYER_MATRIX [0:63] = '{
    6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
    6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
    6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
    6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
    6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
    6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
    6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
    6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
  };

  function automatic logic [LUMA_SUM_W-1:0] bayer_threshold(
    input logic [2:0] row,
    input logic [2:0] col
  );
    return LUMA_SUM_W'(BAYER_MATRIX[{row, col}]) * LUMA_SUM_W'(THRESH_SCALE);
  endfunction

endpackage

// ===== rtl/bdg_position.sv =====
// column and row counters of the raster scan, with dimension clamping
// depends on bdg_pkg and bayer_dither_gray4_packer_defines.svh
`timescale 1ns / 1ps
`include "bayer_dither_gray4_packer_defines.svh"

module bdg_position #(
  parameter int unsigned MAX_DIMENSION = bdg_pkg::MAX_DIMENSION_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic [bdg_pkg::CFG_DIM_W-1:0]  image_width,
  input  logic [bdg_pkg::CFG_DIM_W-1:0]  image_height,
  output bdg_pkg::pos_t                  pos
);
  import bdg_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIMENSION);
  localparam int unsigned CMPW = (CW + 1 > CFG_DIM_W) ? CW + 1 : CFG_DIM_W;

  logic [CW-1:0]   column_position;
  logic [CW-1:0]   row_position;
  logic [CMPW-1:0] width_m1;
  logic [CMPW-1:0] height_m1;
  logic [CW+9:0]   col_ext;
  logic [CW+9:0]   row_ext;
  logic            last_col;
  logic            last_row;

  // last index of each dimension, 0 acting as 1 and large values clamped
  function automatic logic [CMPW-1:0] dim_last(input logic [CFG_DIM_W-1:0] v);
    logic [CMPW-1:0] ve;
    ve = CMPW'(v);
    if (ve == '0) begin
      return '0;
    end else if (ve > CMPW'(MAX_DIMENSION)) begin
      return CMPW'(MAX_DIMENSION - 1);
    end else begin
      return ve - CMPW'(1);
    end
  endfunction

  always_comb begin
    width_m1 = dim_last(image_width);
    height_m1 = dim_last(image_height);
    last_col = CMPW'(column_position) >= width_m1;
    last_row = CMPW'(row_position) >= height_m1;
    col_ext = (CW + 10)'(column_position);
    row_ext = (CW + 10)'(row_position);
    pos.byte_column = col_ext[9:1];
    pos.row_index = row_ext[9:0];
    pos.bayer_col = col_ext[2:0];
    pos.bayer_row = row_ext[2:0];
    pos.last_col = last_col;
    pos.last_row = last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position <= '0;
    end else if (advance) begin
      if (last_col) begin
        column_position <= '0;
        row_position <= last_row ? '0 : row_position + CW'(1);
      end else begin
        column_position <= column_position + CW'(1);
      end
    end
  end

  `BDG_ASSERT_NEXT(a_col_wraps, clk, rst, advance && last_col, column_position == '0, "column did not wrap")
  `BDG_ASSERT_NEXT(a_image_wraps, clk, rst, advance && last_col && last_row, row_position == '0, "row did not wrap at image end")
  `BDG_ASSERT_NEXT(a_hold_idle, clk, rst, !advance, $stable(column_position) && $stable(row_position), "counters moved without a pixel")

endmodule

// ===== rtl/bdg_pack.sv =====
// gray conversion, bayer threshold, nibble pairing and the output word register
// depends on bdg_pkg and bayer_dither_gray4_packer_defines.svh
`timescale 1ns / 1ps
`include "bayer_dither_gray4_packer_defines.svh"

module bdg_pack (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  input  bdg_pkg::pos_t pos,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    packed_byte,
  output logic [8:0]    byte_column,
  output logic [9:0]    row_index,
  output logic          row_end,
  output logic          image_end
);
  import bdg_pkg::*;

  logic [LUMA_SUM_W-1:0] luma_sum;
  logic [LUMA_SUM_W-1:0] threshold;
  logic [3:0]            pixel_idx;
  logic                  take;
  logic                  hold_only;
  logic [7:0]            byte_next;
  logic [3:0]            held_high_nibble;

  always_comb begin
    luma_sum = LUMA_SUM_W'(red) * LUMA_SUM_W'(LUMA_R)
             + LUMA_SUM_W'(green) * LUMA_SUM_W'(LUMA_G)
             + LUMA_SUM_W'(blue) * LUMA_SUM_W'(LUMA_B);
    threshold = bayer_threshold(pos.bayer_row, pos.bayer_col);
    pixel_idx = (luma_sum >= threshold) ? IDX_WHITE : IDX_BLACK;
    in_ready = !out_valid || out_ready;
    take = in_valid && in_ready;
    hold_only = !pos.bayer_col[0] && !pos.last_col;
    // even column at row end flushes with a zero low nibble
    byte_next = pos.bayer_col[0] ? {held_high_nibble, pixel_idx} : {pixel_idx, 4'h0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held_high_nibble <= '0;
    end else if (take) begin
      if (hold_only) begin
        held_high_nibble <= pixel_idx;
        out_valid <= 1'b0;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !hold_only) begin
      packed_byte <= byte_next;
      byte_column <= pos.byte_column;
      row_index <= pos.row_index;
      row_end <= pos.last_col;
      image_end <= pos.last_col && pos.last_row;
    end
  end

  `BDG_ASSERT_NOW(a_end_in_row, clk, rst, out_valid && image_end, row_end, "image end without row end")
  `BDG_ASSERT_NOW(a_nibbles, clk, rst, out_valid, (packed_byte[3:0] == IDX_WHITE || packed_byte[3:0] == IDX_BLACK) && (packed_byte[7:4] == IDX_WHITE || packed_byte[7:4] == IDX_BLACK), "nibble is not a palette index")
  `BDG_ASSERT_NEXT(a_hold_no_word, clk, rst, take && hold_only && out_ready, !out_valid, "word made from held nibble alone")

endmodule

// ===== rtl/bayer_dither_gray4_packer.sv =====
// Ordered-dither gray-4 packer: rgb pixels in, packed 4-bit palette bytes out.
// A closing pixel, once accepted, passes the input register and then the output
// register before its result word is valid. Throughput: one pixel per cycle when
// m_axis_tready does not stall, set by the single-pass quantize path between the two registers.
// Reset: counters, held nibble and valid flags clear; width 492, height 560, no swap.
// depends on bdg_pkg, bdg_position, bdg_pack
`timescale 1ns / 1ps

module bayer_dither_gray4_packer #(
  parameter int unsigned MAX_DIMENSION = bdg_pkg::MAX_DIMENSION_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bdg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bdg_pkg::CFG_DIM_W-1:0]   cfg_wdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // red, green, blue
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // packed_byte, byte_column, row_index
  output logic                            m_axis_tlast,  // row_end
  output logic                            m_axis_tuser   // image_end
);
  import bdg_pkg::*;

  logic [CFG_DIM_W-1:0] image_width;
  logic [CFG_DIM_W-1:0] image_height;
  logic                 swap_red_blue;

  logic          accept;
  logic          pack_ready;
  pos_t          cur_pos;
  logic          s1_valid;
  logic [7:0]    s1_red;
  logic [7:0]    s1_green;
  logic [7:0]    s1_blue;
  pos_t          s1_pos;
  logic [7:0]    packed_byte;
  logic [8:0]    byte_column;
  logic [9:0]    row_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      swap_red_blue <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_addr))
        REG_IMAGE_WIDTH: image_width <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        REG_SWAP_RB: swap_red_blue <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !s1_valid || pack_ready;
  assign accept = s_axis_tvalid && s_axis_tready;

  bdg_position #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_position (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .image_width (image_width),
    .image_height(image_height),
    .pos         (cur_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (pack_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_red <= swap_red_blue ? s_axis_tdata[23:16] : s_axis_tdata[7:0];
      s1_green <= s_axis_tdata[15:8];
      s1_blue <= swap_red_blue ? s_axis_tdata[7:0] : s_axis_tdata[23:16];
      s1_pos <= cur_pos;
    end
  end

  bdg_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s1_valid),
    .in_ready   (pack_ready),
    .red        (s1_red),
    .green      (s1_green),
    .blue       (s1_blue),
    .pos        (s1_pos),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .packed_byte(packed_byte),
    .byte_column(byte_column),
    .row_index  (row_index),
    .row_end    (m_axis_tlast),
    .image_end  (m_axis_tuser)
  );

  assign m_axis_tdata = {5'b0, row_index, byte_column, packed_byte};

endmodule
